[hw/rtl/circ_pkg.sv]
// circ_pkg: shared types and constants of the circle outline and span rasterizer
// used by circ_walk, circ_emit and the top level; no dependencies

package circ_pkg;

  // input field widths
  localparam int CTR_W = 15;
  localparam int RAD_W = 14;
  // walk state widths
  localparam int OFF_W = 15;
  localparam int DEC_W = 17;
  localparam int ADV_W = 19;   // headroom for the decision update
  localparam int SUM_W = 17;   // full precision of center +- offset
  // output coordinate width
  localparam int OUT_W = 16;
  localparam int COORD_BITS_DEF = 16;

  // stream payload layout
  localparam int S_TDATA_W = 48;   // 45 bits of fields padded to bytes
  localparam int M_TDATA_W = 4 * OUT_W;
  localparam int M_TUSER_W = 2;
  localparam int TU_DONE = 0;
  localparam int TU_NOPT = 1;

  // command codes
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef enum logic [1:0] {
    GRP_NONE    = 2'd0,
    GRP_OUTLINE = 2'd1,
    GRP_FILLED  = 2'd2
  } grp_kind_t;

  // one group of results handed from the walk to the emitter
  typedef struct packed {
    grp_kind_t                 kind;
    logic signed [CTR_W-1:0]   cx;
    logic signed [CTR_W-1:0]   cy;
    logic signed [OFF_W-1:0]   ox;
    logic signed [OFF_W-1:0]   oy;
    logic                      done;
  } group_t;

endpackage

[hw/rtl/circ_walk.sv]
// circ_walk: circle walk state and the per-item decision update
// depends on circ_pkg

module circ_walk (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           command,
  input  logic signed [circ_pkg::CTR_W-1:0] center_x,
  input  logic signed [circ_pkg::CTR_W-1:0] center_y,
  input  logic [circ_pkg::RAD_W-1:0]     radius,
  input  logic                           filled,
  output circ_pkg::group_t               grp
);
  import circ_pkg::*;

  logic signed [CTR_W-1:0] held_center_x;
  logic signed [CTR_W-1:0] held_center_y;
  logic [RAD_W-1:0]        held_radius;
  logic                    held_filled;
  logic signed [OFF_W-1:0] offset_x;
  logic signed [OFF_W-1:0] offset_y;
  logic signed [DEC_W-1:0] decision;
  logic                    active;

  logic                    is_begin;
  logic signed [CTR_W-1:0] cur_cx;
  logic signed [CTR_W-1:0] cur_cy;
  logic [RAD_W-1:0]        cur_r;
  logic                    cur_filled;
  logic signed [OFF_W-1:0] cur_ox;
  logic signed [OFF_W-1:0] cur_oy;
  logic signed [DEC_W-1:0] cur_d;
  logic                    cur_act;
  logic                    live;
  logic signed [ADV_W-1:0] d_w, ox_w, oy_w, r_w;
  logic signed [ADV_W-1:0] nd, nox, noy;
  logic                    done;

  always_comb begin
    is_begin   = (command == CMD_BEGIN);
    cur_cx     = is_begin ? center_x : held_center_x;
    cur_cy     = is_begin ? center_y : held_center_y;
    cur_r      = is_begin ? radius : held_radius;
    cur_filled = is_begin ? filled : held_filled;
    cur_ox     = is_begin ? '0 : offset_x;
    cur_oy     = is_begin ? $signed({1'b0, radius}) : offset_y;
    cur_d      = is_begin ? $signed({3'b000, radius}) - 17'sd1 : decision;
    cur_act    = is_begin | active;
    live       = cur_act && !(cur_oy < cur_ox);

    d_w  = ADV_W'(cur_d);
    ox_w = ADV_W'(cur_ox);
    oy_w = ADV_W'(cur_oy);
    r_w  = $signed({5'b00000, cur_r});
    if (d_w >= (ox_w <<< 1)) begin
      nd  = d_w - ((ox_w <<< 1) + 19'sd1);
      nox = ox_w + 19'sd1;
      noy = oy_w;
    end else if (d_w < ((r_w - oy_w) <<< 1)) begin
      nd  = d_w + (oy_w <<< 1) - 19'sd1;
      nox = ox_w;
      noy = oy_w - 19'sd1;
    end else begin
      nd  = d_w + ((oy_w - ox_w - 19'sd1) <<< 1);
      nox = ox_w + 19'sd1;
      noy = oy_w - 19'sd1;
    end
    done = (noy < nox);

    grp.kind = live ? (cur_filled ? GRP_FILLED : GRP_OUTLINE) : GRP_NONE;
    grp.cx   = cur_cx;
    grp.cy   = cur_cy;
    grp.ox   = cur_ox;
    grp.oy   = cur_oy;
    grp.done = live ? done : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_x <= '0;
      held_center_y <= '0;
      held_radius   <= '0;
      held_filled   <= 1'b0;
      offset_x      <= '0;
      offset_y      <= '0;
      decision      <= '0;
      active        <= 1'b0;
    end else if (accept) begin
      held_center_x <= cur_cx;
      held_center_y <= cur_cy;
      held_radius   <= cur_r;
      held_filled   <= cur_filled;
      if (live) begin
        offset_x <= $signed(nox[OFF_W-1:0]);
        offset_y <= $signed(noy[OFF_W-1:0]);
        decision <= $signed(nd[DEC_W-1:0]);
        active   <= !done;
      end else begin
        offset_x <= cur_ox;
        offset_y <= cur_oy;
        decision <= cur_d;
        active   <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/circ_emit.sv]
// circ_emit: group register, result sequencer and output register
// depends on circ_pkg

module circ_emit #(
  parameter int COORD_BITS = circ_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             grp_load,
  input  circ_pkg::group_t                 grp_in,
  output logic                             grp_ready,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [circ_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic [circ_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
  import circ_pkg::*;

  group_t                  grp;
  logic                    grp_valid;
  logic [2:0]              idx;

  logic [2:0]              last_idx;
  logic                    is_last;
  logic                    load_out;
  logic                    outer;
  logic signed [OFF_W-1:0] a, b;
  logic                    xneg, yneg;
  logic signed [SUM_W-1:0] xs, xe, yv;
  logic [M_TDATA_W-1:0]    tdata_next;
  logic [M_TUSER_W-1:0]    tuser_next;

  // wrap to COORD_BITS two's complement, then present in the 16 bit field
  function automatic logic [OUT_W-1:0] wrap_coord(input logic signed [SUM_W-1:0] v);
    logic signed [32:0]           full;
    logic signed [COORD_BITS-1:0] w;
    logic signed [31:0]           e;
    full = 33'(v);
    w    = $signed(full[COORD_BITS-1:0]);
    e    = 32'(w);
    return e[OUT_W-1:0];
  endfunction

  always_comb begin
    outer    = (idx == 3'd0) || (idx == 3'd3);
    a        = grp.ox;
    b        = grp.oy;
    xneg     = 1'b0;
    yneg     = 1'b0;
    last_idx = 3'd0;
    case (grp.kind)
      GRP_OUTLINE: begin
        a        = idx[0] ? grp.oy : grp.ox;
        b        = idx[0] ? grp.ox : grp.oy;
        xneg     = idx[1];
        yneg     = idx[2];
        last_idx = 3'd7;
      end
      GRP_FILLED: begin
        // rows +-ox carry the wide spans of half width oy
        a        = outer ? grp.oy : grp.ox;
        b        = outer ? grp.ox : grp.oy;
        xneg     = 1'b1;
        yneg     = idx[1];
        last_idx = 3'd3;
      end
      default: begin
        last_idx = 3'd0;
      end
    endcase

    xs = SUM_W'(grp.cx) + (xneg ? -SUM_W'(a) : SUM_W'(a));
    xe = (grp.kind == GRP_FILLED) ? SUM_W'(grp.cx) + SUM_W'(a) : xs;
    yv = SUM_W'(grp.cy) + (yneg ? -SUM_W'(b) : SUM_W'(b));

    if (grp.kind == GRP_NONE) begin
      tdata_next          = '0;
      tuser_next          = '0;
      tuser_next[TU_NOPT] = 1'b1;
      tuser_next[TU_DONE] = 1'b1;
    end else begin
      tdata_next          = {wrap_coord(yv), wrap_coord(xe), wrap_coord(yv), wrap_coord(xs)};
      tuser_next          = '0;
      tuser_next[TU_DONE] = grp.done;
    end

    is_last   = (idx == last_idx);
    load_out  = grp_valid && (!m_axis_tvalid || m_axis_tready);
    grp_ready = !grp_valid || (load_out && is_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid     <= 1'b0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        idx <= is_last ? 3'd0 : idx + 3'd1;
      end
      if (grp_load) begin
        grp_valid <= 1'b1;
      end else if (load_out && is_last) begin
        grp_valid <= 1'b0;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp <= grp_in;
    end
    if (load_out) begin
      m_axis_tdata <= tdata_next;
      m_axis_tlast <= is_last;
      m_axis_tuser <= tuser_next;
    end
  end

endmodule

[hw/rtl/circle_outline_and_span_rasterizer.sv]
// circle_outline_and_span_rasterizer: top level of the circle rasterizer
// depends on circ_pkg, circ_walk and circ_emit
//
// usage
//   slave stream carries commands: tuser selects begin (load center, radius and
//   mode, emit first group) or next (emit following group). master stream
//   carries one point or span per item; tlast marks the last item caused by
//   one command, tuser flags circle done and no point.
//   outline mode gives eight points per command, filled mode four spans, and
//   a next command with no circle active gives a single empty done item.
// pipeline
//   an accepted command passes through the group register and then the
//   output register; results then leave one per cycle while m_axis_tready
//   is high, and a command gives 8 items (outline), 4 (filled) or 1 (empty).
//   the single output port is what sets this rate. the next command is taken in
//   the cycle the last result of the current group moves into the output register.
// reset
//   rst is synchronous; it drops all valids and clears the walk state, so
//   no circle is active afterward.
// stalls
//   while m_axis_tready is low the output item holds, the group register
//   holds, and s_axis_tready stays low once a group is waiting.

module circle_outline_and_span_rasterizer #(
  parameter int COORD_BITS = circ_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // center_x[14:0], center_y[29:15], radius[43:30], filled[44], zero pad
  input  logic [circ_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48]
  output logic [circ_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // last_of_group
  output logic                           m_axis_tlast,
  // circle_done[0], no_point[1]
  output logic [circ_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import circ_pkg::*;

  logic   accept;
  logic   grp_ready;
  group_t grp;

  // an item is taken whenever the group register is free or freeing
  assign s_axis_tready = grp_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // walk state and decision update, one group per accepted item
  circ_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .command  (s_axis_tuser),
    .center_x ($signed(s_axis_tdata[CTR_W-1:0])),
    .center_y ($signed(s_axis_tdata[2*CTR_W-1:CTR_W])),
    .radius   (s_axis_tdata[2*CTR_W+RAD_W-1:2*CTR_W]),
    .filled   (s_axis_tdata[2*CTR_W+RAD_W]),
    .grp      (grp)
  );

  // group register feeding one result per cycle into the output register while m_axis is not stalled
  circ_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .grp_load      (accept),
    .grp_in        (grp),
    .grp_ready     (grp_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[hw/rtl/circ_check.sv]
// circ_check: port level checks of the circle rasterizer, bound to the top level
// depends on circ_pkg

module circ_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [circ_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic [circ_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import circ_pkg::*;

  // a stalled item holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // an empty item is alone, done and carries zero coordinates
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[TU_NOPT] |->
      m_axis_tlast && m_axis_tuser[TU_DONE] && (m_axis_tdata == '0))
    else $error("empty item malformed");

  // every row result has y_end equal to y_start
  a_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[4*OUT_W-1:3*OUT_W] == m_axis_tdata[2*OUT_W-1:OUT_W])
    else $error("y_end differs from y_start");

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // output wakes from idle only once an accepted command has passed the group register
  a_lat: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result came out too early");

endmodule

bind circle_outline_and_span_rasterizer circ_check u_check (.*);
